### hdl/adpcm4_pkg.sv
// shared types, tables and helper functions for the 4-bit adpcm encoder
`timescale 1ns / 1ps

package adpcm4_pkg;

  localparam int unsigned StepEntries = 89;
  localparam logic [6:0] StepIdxMax = 7'd88;

  localparam logic signed [17:0] PredMax = 18'sd32767;
  localparam logic signed [17:0] PredMin = -18'sd32768;

  localparam logic [14:0] StepTab [StepEntries] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
    15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
    15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
    15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
    15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
    15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
    15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
    15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
    15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
    logic               clear_state;
  } adpcm4_in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       block_end;
  } adpcm4_out_t;

  // quantizer result toward the sequencer
  typedef struct packed {
    logic        done;
    logic [2:0]  q;
    logic [15:0] rec;
  } adpcm4_qres_t;

  // code handed to the byte packer
  typedef struct packed {
    logic       push;
    logic [3:0] code;
    logic       last;
  } adpcm4_code_t;

  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] res;
    if (idx > StepIdxMax) begin
      res = StepTab[StepIdxMax];
    end else begin
      res = StepTab[idx];
    end
    return res;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] q);
    logic signed [4:0] res;
    case (q)
      3'd4:    res = 5'sd2;
      3'd5:    res = 5'sd4;
      3'd6:    res = 5'sd6;
      3'd7:    res = 5'sd8;
      default: res = -5'sd1;
    endcase
    return res;
  endfunction

endpackage

### hdl/adpcm4_qunit.sv
// iterative quantizer: one compare-subtract per cycle gives the 3-bit code and reconstruction
`timescale 1ns / 1ps

module adpcm4_qunit
  import adpcm4_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [15:0]  mag_i,
  input  logic [14:0]  step_i,
  output adpcm4_qres_t qres_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  bit_q, bit_d;
  logic [17:0] rem_q, rem_d;
  logic [17:0] acc_q, acc_d;
  logic [14:0] step_q, step_d;
  logic [2:0]  q_q, q_d;

  logic [17:0] shifted;
  logic        ge;

  assign shifted = {3'b000, step_q} << bit_q;
  assign ge      = rem_q >= shifted;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    step_d = step_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = 2'd2;
      rem_d  = {mag_i, 2'b00};
      acc_d  = '0;
      step_d = step_i;
      q_d    = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d        = rem_q - shifted;
        acc_d        = acc_q + shifted;
        q_d[bit_q]   = 1'b1;
      end
      if (bit_q == 2'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    step_q <= step_d;
    q_q    <= q_d;
  end

  assign qres_o.done = done_q;
  assign qres_o.q    = q_q;
  assign qres_o.rec  = acc_q[17:2] + {4'b0000, step_q[14:3]};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("quantizer started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("quantizer done without a running division");

endmodule

### hdl/adpcm4_pack.sv
// nibble packer with output register: two codes per byte, odd block end flushed
`timescale 1ns / 1ps

module adpcm4_pack
  import adpcm4_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  adpcm4_code_t code_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output adpcm4_out_t  out_beat_o
);

  logic        phase_q;
  logic [3:0]  held_q;
  logic        out_valid_q;
  adpcm4_out_t out_q;

  assign ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (code_i.push && ready_o) begin
        if (!phase_q) begin
          if (code_i.last) begin
            out_valid_q <= 1'b1;
            held_q      <= '0;
          end else begin
            held_q  <= code_i.code;
            phase_q <= 1'b1;
          end
        end else begin
          out_valid_q <= 1'b1;
          held_q      <= '0;
          phase_q     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_i.push && ready_o) begin
      if (!phase_q) begin
        out_q.packed_byte <= {code_i.code, 4'b0000};
        out_q.block_end   <= 1'b1;
      end else begin
        out_q.packed_byte <= {held_q, code_i.code};
        out_q.block_end   <= code_i.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### hdl/adpcm_4bit_encoder.sv
// top level: sample sequencer, predictor and step index state, quantizer and packer
// each sample passes the prep, quantize, update and emit states, then the packer's output register
// a new sample is taken only in idle, after the last one is emitted; the quantizer loop runs one code bit per cycle
// a byte leaves after every second sample, or at once for an odd sample marked last
// reset clears predictor, step index, nibble phase and the pending output beat
`timescale 1ns / 1ps

module adpcm_4bit_encoder
  import adpcm4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  adpcm4_in_t  in_beat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output adpcm4_out_t out_beat_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_QUANT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic signed [15:0] pred_q;
  logic [6:0]         idx_q;
  adpcm4_in_t         beat_q;
  logic               sign_q;
  logic [14:0]        step_q;
  logic [2:0]         q_q;
  logic [15:0]        rec_q;

  logic signed [15:0] pred_eff;
  logic [6:0]         idx_eff;
  logic signed [16:0] diff;
  logic [16:0]        mag_full;
  logic [15:0]        mag;
  logic [14:0]        step_now;
  logic               q_start;
  adpcm4_qres_t       qres;

  logic signed [17:0] pred_ext;
  logic signed [17:0] rec_ext;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_new;
  logic signed [8:0]  idx_sum;
  logic [6:0]         idx_new;
  logic signed [4:0]  adj;

  adpcm4_code_t code;
  logic         pack_ready;

  assign in_ready_o = (state_q == ST_IDLE);

  // clear flag stands in for a predictor and step index reset ahead of coding
  assign pred_eff = beat_q.clear_state ? 16'sd0 : pred_q;
  assign idx_eff  = beat_q.clear_state ? 7'd0 : idx_q;
  assign diff     = {beat_q.sample[15], beat_q.sample} - {pred_eff[15], pred_eff};
  assign mag_full = diff[16] ? 17'(17'sd0 - diff) : 17'(diff);
  assign mag      = mag_full[15:0];
  assign step_now = step_lookup(idx_eff);
  assign q_start  = (state_q == ST_PREP);

  adpcm4_qunit u_qunit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (q_start),
    .mag_i   (mag),
    .step_i  (step_now),
    .qres_o  (qres)
  );

  // predictor update with 16-bit saturation
  assign pred_ext = {{2{pred_q[15]}}, pred_q};
  assign rec_ext  = {2'b00, rec_q};
  assign pred_sum = sign_q ? (pred_ext - rec_ext) : (pred_ext + rec_ext);

  always_comb begin
    if (pred_sum > PredMax) begin
      pred_new = 16'sd32767;
    end else if (pred_sum < PredMin) begin
      pred_new = -16'sd32768;
    end else begin
      pred_new = pred_sum[15:0];
    end
  end

  assign adj     = index_adjust(q_q);
  assign idx_sum = $signed({2'b00, idx_q}) + $signed({{4{adj[4]}}, adj});

  always_comb begin
    if (idx_sum < 9'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > $signed({2'b00, StepIdxMax})) begin
      idx_new = StepIdxMax;
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  assign code.push = (state_q == ST_EMIT);
  assign code.code = {sign_q, q_q};
  assign code.last = beat_q.last_sample;

  adpcm4_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_i      (code),
    .ready_o     (pack_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pred_q  <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          pred_q  <= pred_eff;
          idx_q   <= (idx_eff > StepIdxMax) ? StepIdxMax : idx_eff;
          state_q <= ST_QUANT;
        end
        ST_QUANT: begin
          if (qres.done) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          pred_q  <= pred_new;
          idx_q   <= idx_new;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (pack_ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_beat_i;
    end
    if (state_q == ST_PREP) begin
      sign_q <= diff[16];
      step_q <= step_now;
    end
    if (state_q == ST_QUANT && qres.done) begin
      q_q   <= qres.q;
      rec_q <= qres.rec;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= StepIdxMax)
    else $error("step index beyond table");

  a_done_in_quant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qres.done |-> state_q == ST_QUANT)
    else $error("quantizer result outside quantize state");

  a_step_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |-> step_q == step_lookup(idx_q))
    else $error("latched step does not match step index");

endmodule
